FILE: hdl/rpfa_pkg.sv
// Shared constants, codes and beat types of the reference-counted page-frame allocator.
`default_nettype none

package rpfa_pkg;

    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam int COUNT_W    = 8;
    localparam int ADDR_W     = 34;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);
    localparam int BASE_W     = ADDR_W + 1;
    localparam int WIDE_W     = ADDR_W + 2;
    localparam int STATUS_W   = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ADDR_W-1:0] LOWEST_RESET = ADDR_W'(34'h0_8000_0000);
    localparam logic [ADDR_W-1:0] TOP_RESET    = ADDR_W'(34'h0_8800_0000);

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REF   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INIT  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_ALLOC    = 4'd0;
    localparam logic [STATUS_W-1:0] STAT_RETURNED = 4'd1;
    localparam logic [STATUS_W-1:0] STAT_STILL    = 4'd2;
    localparam logic [STATUS_W-1:0] STAT_REFADD   = 4'd3;
    localparam logic [STATUS_W-1:0] STAT_OOM      = 4'd4;
    localparam logic [STATUS_W-1:0] STAT_BAD      = 4'd5;
    localparam logic [STATUS_W-1:0] STAT_NOTALLOC = 4'd6;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 4'd7;
    localparam logic [STATUS_W-1:0] STAT_INIT     = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_LOWEST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] page_address;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   result_address;
        logic [COUNT_W-1:0]  reference_count;
    } res_t;

endpackage

`default_nettype wire

FILE: hdl/refcounted_page_frame_allocator.sv
// Top level of the reference-counted page-frame allocator.
//
// Command channel: cmd is taken at a rising edge with start high and busy low.
// Result channel: done is high for one cycle with result valid; it cannot be
// held off, so the receiver must take every beat as it comes.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 lowest
// address, 1 top address) at the next edge; write only while idle.
// Allocate, free and add reference: the accepting edge registers the reads of
// the count and stack memories, then S_EXEC modifies, writes back and registers
// the result, so done rises in the cycle after the accepting edge and busy is
// high only in S_EXEC. Each memory has a single read and a single write port.
// Initialise sweeps every count entry, one a cycle, clearing it and pushing
// pages that fit, with busy high throughout, then one done beat with init done.
// Reset runs the same clearing pass with busy high and no result;
// the free stack is left empty and its contents are not cleared.
// Results come from registers and never depend on the receiver.
`default_nettype none

module refcounted_page_frame_allocator
    import rpfa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire cmd_t                 cmd,
    output logic                      done,
    output res_t                      result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_wdata
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    lowest_reg, top_reg;
    logic [BASE_W-1:0]    base_reg, base_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [IDX_W-1:0]     clr_idx_reg, clr_idx_next;
    logic                 init_run_reg, init_run_next;
    logic                 done_reg, done_next;
    res_t                 res_reg, res_next;
    logic [MODE_W-1:0]    mode_reg;
    logic                 addr_ok_reg;
    logic [WIDE_W-1:0]    p_reg, p_next;

    logic [IDX_W-1:0]     stack_mem [NUM_PAGES];
    logic [COUNT_W-1:0]   count_mem [NUM_PAGES];
    logic [IDX_W-1:0]     stk_rdata_reg;
    logic [COUNT_W-1:0]   cnt_rdata_reg;

    logic                 accept;
    logic [WIDE_W-1:0]    diff;
    logic [WIDE_W-PAGE_SHIFT-1:0] idx_wide;
    logic                 addr_ok;
    logic [IDX_W-1:0]     cnt_raddr, stk_raddr;
    logic                 stk_we, cnt_we;
    logic [IDX_W-1:0]     stk_waddr, cnt_waddr, stk_wdata;
    logic [COUNT_W-1:0]   cnt_wdata, cnt_dec, cnt_inc;
    logic                 fits;
    logic                 stack_room;
    logic [BASE_W-1:0]    round_up;
    logic [BASE_W-1:0]    alloc_addr;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;
    assign accept = start && (state_reg == S_IDLE);

    assign diff     = WIDE_W'(cmd.page_address) - WIDE_W'(base_reg);
    assign idx_wide = diff[WIDE_W-1:PAGE_SHIFT];
    assign addr_ok  = (cmd.page_address[PAGE_SHIFT-1:0] == '0)
                   && (cmd.page_address >= lowest_reg)
                   && (BASE_W'(cmd.page_address) >= base_reg)
                   && (cmd.page_address < top_reg)
                   && (idx_wide < (WIDE_W-PAGE_SHIFT)'(NUM_PAGES));

    assign cnt_raddr = idx_wide[IDX_W-1:0];
    assign stk_raddr = IDX_W'(depth_reg - DEPTH_W'(1));

    assign fits       = (p_reg + WIDE_W'(PAGE_BYTES)) <= WIDE_W'(top_reg);
    assign stack_room = depth_reg < DEPTH_W'(NUM_PAGES);
    assign cnt_dec    = cnt_rdata_reg - COUNT_W'(1);
    assign cnt_inc    = cnt_rdata_reg + COUNT_W'(1);
    assign alloc_addr = base_reg + (BASE_W'(stk_rdata_reg) << PAGE_SHIFT);
    assign round_up   = BASE_W'(cfg_wdata) + BASE_W'(PAGE_BYTES - 1);

    always_comb
    begin
        base_next = base_reg;
        if (cfg_we && cfg_index == REG_LOWEST)
        begin
            base_next = {round_up[BASE_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        clr_idx_next  = clr_idx_reg;
        init_run_next = init_run_reg;
        p_next        = p_reg;
        done_next     = 1'b0;
        res_next      = '0;
        stk_we        = 1'b0;
        stk_waddr     = depth_reg[IDX_W-1:0];
        stk_wdata     = '0;
        cnt_we        = 1'b0;
        cnt_waddr     = '0;
        cnt_wdata     = '0;

        case (state_reg)
            S_CLEAR:
            begin
                cnt_we       = 1'b1;
                cnt_waddr    = clr_idx_reg;
                p_next       = p_reg + WIDE_W'(PAGE_BYTES);
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (init_run_reg && fits)
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = clr_idx_reg;
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                if (clr_idx_reg == IDX_W'(NUM_PAGES - 1))
                begin
                    state_next      = S_IDLE;
                    init_run_next   = 1'b0;
                    done_next       = init_run_reg;
                    res_next.status = STAT_INIT;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.mode == MODE_INIT)
                    begin
                        state_next    = S_CLEAR;
                        clr_idx_next  = '0;
                        depth_next    = '0;
                        init_run_next = 1'b1;
                        p_next        = WIDE_W'(base_reg);
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (depth_reg == '0)
                        begin
                            res_next.status = STAT_OOM;
                        end
                        else
                        begin
                            cnt_we                   = 1'b1;
                            cnt_waddr                = stk_rdata_reg;
                            cnt_wdata                = COUNT_W'(1);
                            depth_next               = depth_reg - DEPTH_W'(1);
                            res_next.status          = STAT_ALLOC;
                            res_next.result_address  = alloc_addr[ADDR_W-1:0];
                            res_next.reference_count = COUNT_W'(1);
                        end
                    end

                    MODE_FREE:
                    begin
                        if (!addr_ok_reg)
                        begin
                            res_next.status = STAT_BAD;
                        end
                        else if (cnt_rdata_reg == '0)
                        begin
                            res_next.status = STAT_NOTALLOC;
                        end
                        else
                        begin
                            cnt_we    = 1'b1;
                            cnt_waddr = clr_idx_reg;
                            cnt_wdata = cnt_dec;
                            if (cnt_dec == '0)
                            begin
                                res_next.status = STAT_RETURNED;
                                if (stack_room)
                                begin
                                    stk_we     = 1'b1;
                                    stk_wdata  = clr_idx_reg;
                                    depth_next = depth_reg + DEPTH_W'(1);
                                end
                            end
                            else
                            begin
                                res_next.status          = STAT_STILL;
                                res_next.reference_count = cnt_dec;
                            end
                        end
                    end

                    MODE_REF:
                    begin
                        if (!addr_ok_reg)
                        begin
                            res_next.status = STAT_BAD;
                        end
                        else if (cnt_rdata_reg == {COUNT_W{1'b1}})
                        begin
                            res_next.status          = STAT_OVERFLOW;
                            res_next.reference_count = cnt_rdata_reg;
                        end
                        else
                        begin
                            cnt_we                   = 1'b1;
                            cnt_waddr                = clr_idx_reg;
                            cnt_wdata                = cnt_inc;
                            res_next.status          = STAT_REFADD;
                            res_next.reference_count = cnt_inc;
                        end
                    end

                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            depth_reg    <= '0;
            clr_idx_reg  <= '0;
            init_run_reg <= 1'b0;
            done_reg     <= 1'b0;
            lowest_reg   <= LOWEST_RESET;
            top_reg      <= TOP_RESET;
            base_reg     <= BASE_W'(LOWEST_RESET);
        end
        else
        begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            init_run_reg <= init_run_next;
            done_reg     <= done_next;
            base_reg     <= base_next;
            // hold the page index of a free or add reference in the sweep counter
            if (accept && cmd.mode != MODE_INIT)
            begin
                clr_idx_reg <= cnt_raddr;
            end
            else
            begin
                clr_idx_reg <= clr_idx_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOWEST: lowest_reg <= cfg_wdata;
                    REG_TOP:    top_reg    <= cfg_wdata;
                    default:    top_reg    <= top_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        p_reg   <= p_next;
        if (accept)
        begin
            mode_reg    <= cmd.mode;
            addr_ok_reg <= addr_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (accept)
        begin
            stk_rdata_reg <= stack_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (accept)
        begin
            cnt_rdata_reg <= count_mem[cnt_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rpfa_checker.sv
// Port-level checker for the page-frame allocator and its bind.
`default_nettype none

module rpfa_checker
    import rpfa_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire res_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without preceding work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STAT_ALLOC) |-> (result.result_address == '0))
        else $error("address on a result that is not an allocation");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STAT_OOM || result.status == STAT_BAD
                  || result.status == STAT_INIT)) |-> (result.reference_count == '0))
        else $error("count on a result that carries none");

endmodule

bind refcounted_page_frame_allocator rpfa_checker u_rpfa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

FILE: tb/rpfa_prediction_check.sv
// Result checker for the page-frame allocator: tracks the pool, predicts each result and compares.
`timescale 1ns / 1ps

module rpfa_prediction_check
    import rpfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  cmd_t                 cmd,
    input  logic                 done,
    input  res_t                 result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    output int                   fails,
    output int                   outstanding
);

    logic [ADDR_W-1:0]  lowest_q;
    logic [ADDR_W-1:0]  top_q;
    logic [IDX_W-1:0]   free_pages [NUM_PAGES];
    logic [DEPTH_W-1:0] free_depth;
    logic [COUNT_W-1:0] page_counts [NUM_PAGES];
    res_t               pending_outcomes [$];
    res_t               want;

    function automatic res_t predict_page_op(cmd_t c);
        res_t              r;
        logic [IDX_W-1:0]  idx;
        longint unsigned   low;
        longint unsigned   high;
        longint unsigned   addr;
        longint unsigned   base;
        longint unsigned   slot;
        r    = '0;
        low  = lowest_q;
        high = top_q;
        addr = c.page_address;
        base = ((low + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
        case (c.mode)
            MODE_ALLOC:
            begin
                if (free_depth == 0)
                begin
                    r.status = STAT_OOM;
                end
                else
                begin
                    free_depth--;
                    idx = free_pages[free_depth];
                    page_counts[idx] = 1;
                    r.status          = STAT_ALLOC;
                    r.result_address  = ADDR_W'(base + idx * PAGE_BYTES);
                    r.reference_count = 1;
                end
            end
            MODE_INIT:
            begin
                for (int i = 0; i < NUM_PAGES; i++)
                    page_counts[i] = '0;
                slot = (high >= base) ? (high - base) / PAGE_BYTES : 0;
                if (slot > NUM_PAGES)
                    slot = NUM_PAGES;
                for (int i = 0; i < slot; i++)
                    free_pages[i] = IDX_W'(i);
                free_depth = DEPTH_W'(slot);
                r.status   = STAT_INIT;
            end
            default:
            begin
                slot = (addr >= base) ? (addr - base) / PAGE_BYTES : 0;
                idx  = IDX_W'(slot);
                if (addr % PAGE_BYTES != 0 || addr < low || addr < base || addr >= high
                    || slot >= NUM_PAGES)
                begin
                    r.status = STAT_BAD;
                end
                else if (c.mode == MODE_FREE)
                begin
                    if (page_counts[idx] == 0)
                    begin
                        r.status = STAT_NOTALLOC;
                    end
                    else
                    begin
                        page_counts[idx]--;
                        if (page_counts[idx] == 0)
                        begin
                            if (free_depth < NUM_PAGES)
                            begin
                                free_pages[free_depth] = idx;
                                free_depth++;
                            end
                            r.status = STAT_RETURNED;
                        end
                        else
                        begin
                            r.status          = STAT_STILL;
                            r.reference_count = page_counts[idx];
                        end
                    end
                end
                else if (page_counts[idx] == '1)
                begin
                    r.status          = STAT_OVERFLOW;
                    r.reference_count = page_counts[idx];
                end
                else
                begin
                    page_counts[idx]++;
                    r.status          = STAT_REFADD;
                    r.reference_count = page_counts[idx];
                end
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(string field_name, logic [63:0] expected, logic [63:0] actual);
        if (expected !== actual)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field_name, expected, actual);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_q   = LOWEST_RESET;
            top_q      = TOP_RESET;
            free_depth = '0;
            for (int i = 0; i < NUM_PAGES; i++)
                page_counts[i] = '0;
            pending_outcomes.delete();
            fails       = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_LOWEST)
                    lowest_q = cfg_wdata;
                else
                    top_q = cfg_wdata;
            end
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    fails++;
                    $display("%0t: result beat with none expected, status %0d, address %0h",
                             $time, result.status, result.result_address);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    compare_field("status", want.status, result.status);
                    compare_field("result_address", want.result_address,
                                  result.result_address);
                    compare_field("reference_count", want.reference_count,
                                  result.reference_count);
                end
            end
            if (start && !busy)
                pending_outcomes.push_back(predict_page_op(cmd));
            outstanding = pending_outcomes.size();
        end
    end

endmodule

FILE: tb/refcounted_page_frame_allocator_tb.sv
// Testbench top for the page-frame allocator: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module refcounted_page_frame_allocator_tb;
    import rpfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4 * (NUM_PAGES + 64);
    localparam int SETTLE_CYCLES  = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    logic                 done;
    res_t                 result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_wdata;
    int                   fails;
    int                   outstanding;
    int                   stalled_cycles;

    logic [ADDR_W-1:0]    cur_low;
    logic [ADDR_W-1:0]    cur_top;
    logic [ADDR_W-1:0]    hammer_page;
    int                   hammer_left;
    int                   burst_left;

    refcounted_page_frame_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rpfa_prediction_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fails       (fails),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] random_address();
        return {2'($urandom_range(0, 3)), 32'($urandom)};
    endfunction

    // near the top of the pool, where pages are handed out, and a little past it
    function automatic logic [ADDR_W-1:0] window_address();
        longint base;
        longint n;
        longint idx;
        int     k;
        base = ((longint'(cur_low) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
        n    = (longint'(cur_top) > base) ? (longint'(cur_top) - base) / PAGE_BYTES : 0;
        if (n > NUM_PAGES)
            n = NUM_PAGES;
        k   = $urandom_range(0, 23);
        idx = n + 2 - k;
        if ($urandom_range(0, 15) == 0)
            return ADDR_W'(base + idx * PAGE_BYTES + $urandom_range(1, PAGE_BYTES - 1));
        return ADDR_W'(base + idx * PAGE_BYTES);
    endfunction

    task automatic issue(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr);
        @(negedge clk);
        start <= 1'b1;
        cmd   <= cmd_t'{mode, addr};
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic pause(int cycles);
        @(negedge clk);
        start <= 1'b0;
        cmd   <= cmd_t'{2'($urandom_range(0, 3)), random_address()};
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [ADDR_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_registers(logic [ADDR_W-1:0] low, logic [ADDR_W-1:0] high);
        settle();
        write_reg(REG_LOWEST, low);
        write_reg(REG_TOP, high);
        cur_low = low;
        cur_top = high;
    endtask

    task automatic run_phase(int items, bit with_init);
        int pick;
        if (with_init)
            issue(MODE_INIT, random_address());
        for (int i = 0; i < items; i++)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if (hammer_left == 0 && $urandom_range(0, 99) < 2)
            begin
                hammer_page = window_address();
                hammer_left = ($urandom_range(0, 3) == 0) ? 260 : $urandom_range(4, 20);
            end
            if (hammer_left > 0)
            begin
                hammer_left--;
                issue(MODE_REF, hammer_page);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 34)
                    issue(MODE_ALLOC, random_address());
                else if (pick < 64)
                    issue(MODE_FREE, window_address());
                else if (pick < 90)
                    issue(MODE_REF, window_address());
                else if (pick < 95)
                    issue(MODE_FREE, random_address());
                else
                    issue(MODE_REF, random_address());
            end
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_LOWEST;
        cfg_wdata   = '0;
        cur_low     = LOWEST_RESET;
        cur_top     = TOP_RESET;
        hammer_page = '0;
        hammer_left = 0;
        burst_left  = 0;
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        settle();

        issue(MODE_ALLOC, '0);
        issue(MODE_FREE,  34'h0_8000_0000);
        issue(MODE_REF,   34'h0_8000_1000);
        issue(MODE_FREE,  34'h0_8000_1000);
        issue(MODE_ALLOC, '1);
        issue(MODE_FREE,  34'h0_8000_0800);
        issue(MODE_REF,   34'h0_7FFF_F000);
        issue(MODE_FREE,  34'h0_8800_0000);
        issue(MODE_REF,   '1);
        issue(MODE_FREE,  '0);
        issue(MODE_INIT,  '1);
        issue(MODE_ALLOC, '0);
        issue(MODE_REF,   34'h0_87FF_F000);
        issue(MODE_FREE,  34'h0_87FF_F000);
        issue(MODE_FREE,  34'h0_87FF_F000);
        // pool is full here, so this return is dropped
        issue(MODE_REF,   34'h0_8000_0000);
        issue(MODE_FREE,  34'h0_8000_0000);
        issue(MODE_ALLOC, '0);
        issue(MODE_REF,   34'h0_87FF_E000);
        issue(MODE_REF,   34'h0_87FF_E000);
        issue(MODE_ALLOC, '0);
        issue(MODE_FREE,  34'h0_8000_1000);

        set_registers(34'h0_1000_0123, 34'h0_1001_9456);
        hammer_page = 34'h0_1001_8000;
        hammer_left = 260;
        run_phase(400, 1'b1);
        set_registers('0, '1);
        run_phase(200, 1'b1);
        set_registers('1, '0);
        run_phase(80, 1'b0);
        run_phase(40, 1'b1);
        set_registers(34'h2_0000_0000, 34'h2_0000_8000);
        run_phase(200, 1'b1);
        set_registers(34'h2_0000_0000, 34'h2_0000_4001);
        run_phase(100, 1'b0);
        settle();

        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
hdl/rpfa_pkg.sv
hdl/refcounted_page_frame_allocator.sv
hdl/rpfa_checker.sv
tb/rpfa_prediction_check.sv
tb/refcounted_page_frame_allocator_tb.sv
